FILE: hdl/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
// No dependencies; pulled in by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while reset is asserted (active low)
`define PSS_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pss assertion failed");
// Condition that must never be seen at a clock edge
`define PSS_NEVER(name, clk, rstn, cond) \
  `PSS_ASSERT(name, clk, rstn, !(cond))
`else
`define PSS_ASSERT(name, clk, rstn, prop)
`define PSS_NEVER(name, clk, rstn, cond)
`endif
`endif

FILE: hdl/pss_pkg.sv
// Shared types and constants of the step sequencer.
// No dependencies; imported by the interfaces and all modules.
`timescale 1ns / 1ps

package pss_pkg;

  localparam int CfgW   = 8;   // widest configuration register
  localparam int StepW  = 7;   // step position, holds up to 126
  localparam int SubW   = 8;   // substep position
  localparam int NoteW  = 7;
  localparam int DivW   = 32;  // dividend / quotient width
  localparam int DvsW   = 8;   // divisor / remainder width
  localparam int IdxW   = 8;   // widest table address (256 entries)

  // item codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_SEEK  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  localparam logic [7:0] TICKS_RST = 8'd24;
  localparam logic [6:0] STEPS_RST = 7'd16;

  localparam logic [NoteW-1:0] NOTE_RST    = 7'd60;
  localparam logic [NoteW-1:0] VEL_RST     = 7'd0;
  localparam logic [NoteW-1:0] GATE_RST    = 7'd64;
  localparam logic [NoteW-1:0] PROB_ALWAYS = 7'd127;
  localparam logic [DvsW-1:0]  GATE_FULL   = 8'd127;

  typedef enum logic {
    CFG_TICKS = 1'b0,
    CFG_STEPS = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GATE_W,
    ST_SEEK_Q,
    ST_SEEK_R,
    ST_FIN,
    ST_OUT
  } pss_state_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [31:0]      playhead;
    logic [5:0]       step_index;
    logic [NoteW-1:0] note_in;
    logic [NoteW-1:0] velocity_in;
    logic [NoteW-1:0] gate_in;
    logic [NoteW-1:0] probability_in;
    logic [NoteW-1:0] random_value;
  } pss_in_t;

  typedef struct packed {
    logic [NoteW-1:0] note_out;
    logic [NoteW-1:0] velocity_out;
    logic [5:0]       step_now;
    logic [SubW-1:0]  substep_now;
    logic             step_fired;
  } pss_out_t;

  typedef struct packed {
    logic [NoteW-1:0] note;
    logic [NoteW-1:0] vel;
    logic [NoteW-1:0] gate;
    logic [NoteW-1:0] prob;
  } step_entry_t;

  localparam step_entry_t STEP_RST = '{note: NOTE_RST, vel: VEL_RST,
                                       gate: GATE_RST, prob: PROB_ALWAYS};

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
    logic [DvsW-1:0] rem;
  } div_rsp_t;

endpackage

FILE: hdl/pss_if.sv
// Valid/ready channel interfaces for sequencer items and results.
// Depends on pss_pkg for the payload types.
`timescale 1ns / 1ps

interface pss_in_if;
  import pss_pkg::*;
  logic    valid;
  logic    ready;
  pss_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pss_out_if;
  import pss_pkg::*;
  logic     valid;
  logic     ready;
  pss_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/probabilistic_step_sequencer.sv
// Probabilistic step sequencer, top level.
// Depends on pss_pkg, pss_if, pss_div, pss_step_mem and assert_macros.svh.
//
// Use:
//   in_ch  - one transaction per item: tick, seek to playhead, or step write.
//   out_ch - exactly one result transaction per item, in item order.
//   cfg_*  - register writes (ticks per step, steps in use), taken at any
//            edge with cfg_we_i high; the user must issue them only while
//            the block is idle, which the block itself does not enforce.
// Path from the accepting edge to the result register, by item:
//   step write, unused code : straight to the output state
//   tick, substep not zero  : counter update, then output
//   tick at substep zero    : table read, gate product, reciprocal multiply
//                             for the off point, counter update, then output
//   seek                    : two divider passes, playhead by ticks per step,
//                             then quotient by step count, then output
// One item is in flight at a time; both seek passes use the shared divider.
// A new item is accepted in the cycle after the previous result lands in the
// output register, even if the receiver has not yet taken it.
// If the receiver stalls, the finished item waits in the final state until
// the output register frees up. Reset clears counters, sound state and the
// table valid bits at once; the table then reads as note 60, velocity 0,
// gate 64, probability 127 until written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module probabilistic_step_sequencer #(
  parameter int MAX_STEPS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pss_in_if.sink                         in_ch,
  pss_out_if.source                      out_ch,
  input  logic                           cfg_we_i,
  input  pss_pkg::cfg_reg_e              cfg_idx_i,
  input  logic [pss_pkg::CfgW-1:0]       cfg_wdata_i
);
  import pss_pkg::*;

  localparam int AddrW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  // step count can never exceed what steps_in_use (7 bits) can say
  localparam int LenCap = (MAX_STEPS > 127) ? 127 : MAX_STEPS;
  localparam logic [StepW-1:0] LenCapW = StepW'(LenCap);
  // x / 127 == (x * ceil(2^22 / 127)) >> 22, exact for x below 2^15
  localparam logic [15:0] GateRecip = 16'd33027;
  localparam int          RecipSh   = 22;

  // ---- state ----
  pss_state_e       state_q, state_d;
  pss_in_t          item_q;
  logic [14:0]      gate_prod_q;
  logic [7:0]       ticks_q, ticks_d;
  logic [6:0]       steps_q, steps_d;
  logic [SubW-1:0]  substep_q, substep_d;
  logic [StepW-1:0] step_q, step_d;
  logic             enabled_q, enabled_d;
  logic [SubW-1:0]  off_q, off_d;
  logic [NoteW-1:0] snd_note_q, snd_note_d;
  logic [NoteW-1:0] snd_vel_q, snd_vel_d;
  logic             fired_q, fired_d;
  logic             out_valid_q, out_valid_d;
  pss_out_t         out_data_q, out_data_d;

  // ---- combinational helpers ----
  logic             in_acc;
  logic             out_free;
  logic [7:0]       res;
  logic [StepW-1:0] len;
  logic [SubW:0]    sub_inc;
  logic [StepW:0]   step_inc;
  logic [14:0]      gate_prod;
  logic [30:0]      off_prod;
  logic             fire_ok;
  logic             seek_wait;
  logic [IdxW-1:0]  rd_addr_w;
  logic [IdxW-1:0]  wr_addr_w;
  logic             mem_rd_en;
  logic             mem_wr_en;
  step_entry_t      mem_wr_data;
  step_entry_t      mem_rd_data;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  function automatic logic [StepW-1:0] eff_len_f(input logic [6:0] n);
    logic [StepW-1:0] l;
    if (n == '0) begin
      l = StepW'(1);
    end else if (n > LenCapW) begin
      l = LenCapW;
    end else begin
      l = n;
    end
    return l;
  endfunction

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_q || out_ch.ready;
  assign res       = (ticks_q == '0) ? 8'd1 : ticks_q;
  assign len       = eff_len_f(steps_q);
  assign sub_inc   = {1'b0, substep_q} + 1'b1;
  assign step_inc  = {1'b0, step_q} + 1'b1;
  // gate * (resolution - 1), registered ahead of the reciprocal multiply
  assign gate_prod = mem_rd_data.gate * (res - 8'd1);
  assign off_prod  = gate_prod_q * GateRecip;
  assign fire_ok   = (mem_rd_data.prob == PROB_ALWAYS) ||
                     (item_q.random_value < mem_rd_data.prob);
  assign seek_wait = (state_q == ST_SEEK_Q) || (state_q == ST_SEEK_R);
  assign rd_addr_w = IdxW'(step_q);
  assign wr_addr_w = IdxW'(in_ch.data.step_index);

  assign mem_wr_data = '{note: in_ch.data.note_in, vel: in_ch.data.velocity_in,
                         gate: in_ch.data.gate_in, prob: in_ch.data.probability_in};

  pss_step_mem #(
    .Depth (MAX_STEPS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (wr_addr_w[AddrW-1:0]),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (rd_addr_w[AddrW-1:0]),
    .rd_data_o (mem_rd_data)
  );

  pss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.data.func)
            FUNC_TICK: state_d = (substep_q == '0) ? ST_READ : ST_FIN;
            FUNC_SEEK: state_d = ST_SEEK_Q;
            default:   state_d = ST_OUT;   // step write and unused code
          endcase
        end
      end
      ST_READ:   state_d = ST_GATE_W;
      ST_GATE_W: state_d = ST_FIN;
      ST_SEEK_Q: if (div_rsp.done) state_d = ST_SEEK_R;
      ST_SEEK_R: if (div_rsp.done) state_d = ST_OUT;
      ST_FIN:    state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---- FSM outputs: handshake, table and divider control ----
  always_comb begin
    in_ch.ready      = (state_q == ST_IDLE);
    mem_rd_en        = 1'b0;
    mem_wr_en        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = in_ch.data.playhead;
    div_req.divisor  = res;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // table read is cheap, issue it for every tick
          mem_rd_en     = (in_ch.data.func == FUNC_TICK);
          mem_wr_en     = (in_ch.data.func == FUNC_WRITE) &&
                          (32'(in_ch.data.step_index) < MAX_STEPS);
          div_req.start = (in_ch.data.func == FUNC_SEEK);
        end
      end
      ST_SEEK_Q: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = div_rsp.quot;
        div_req.divisor  = DvsW'(len);
      end
      default: ;
    endcase
  end

  // ---- datapath next values ----
  always_comb begin
    ticks_d     = ticks_q;
    steps_d     = steps_q;
    substep_d   = substep_q;
    step_d      = step_q;
    enabled_d   = enabled_q;
    off_d       = off_q;
    snd_note_d  = snd_note_q;
    snd_vel_d   = snd_vel_q;
    fired_d     = fired_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          fired_d = 1'b0;
        end
      end
      ST_GATE_W: begin
        // start of step: probability test and off point
        enabled_d = fire_ok;
        off_d     = off_prod[RecipSh +: SubW] + 1'b1;
        if (fire_ok) begin
          snd_note_d = mem_rd_data.note;
          snd_vel_d  = mem_rd_data.vel;
          fired_d    = 1'b1;
        end
      end
      ST_SEEK_Q: begin
        if (div_rsp.done) begin
          substep_d = div_rsp.rem;
        end
      end
      ST_SEEK_R: begin
        if (div_rsp.done) begin
          step_d = div_rsp.rem[StepW-1:0];
        end
      end
      ST_FIN: begin
        if ((substep_q == off_q) && enabled_q) begin
          snd_note_d = '0;
          snd_vel_d  = '0;
        end
        if (sub_inc >= {1'b0, res}) begin
          substep_d = '0;
          step_d    = (step_inc >= {1'b0, len}) ? '0 : step_inc[StepW-1:0];
        end else begin
          substep_d = sub_inc[SubW-1:0];
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{note_out: snd_note_q, velocity_out: snd_vel_q,
                          step_now: step_q[5:0], substep_now: substep_q,
                          step_fired: fired_q};
        end
      end
      default: ;
    endcase

    // register writes must arrive only while idle; the block does not enforce it
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TICKS: ticks_d = cfg_wdata_i;
        CFG_STEPS: begin
          steps_d = cfg_wdata_i[6:0];
          // shortened pattern: jump back to the top
          if (step_q >= eff_len_f(cfg_wdata_i[6:0])) begin
            step_d    = '0;
            substep_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ticks_q     <= TICKS_RST;
      steps_q     <= STEPS_RST;
      substep_q   <= '0;
      step_q      <= '0;
      enabled_q   <= 1'b0;
      off_q       <= '0;
      snd_note_q  <= '0;
      snd_vel_q   <= '0;
      fired_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ticks_q     <= ticks_d;
      steps_q     <= steps_d;
      substep_q   <= substep_d;
      step_q      <= step_d;
      enabled_q   <= enabled_d;
      off_q       <= off_d;
      snd_note_q  <= snd_note_d;
      snd_vel_q   <= snd_vel_d;
      fired_q     <= fired_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_ch.data;
    end
    if (state_q == ST_READ) begin
      gate_prod_q <= gate_prod;
    end
    out_data_q <= out_data_d;
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_data_q;

  // ---- checks ----
  // divider finishes only while a seek is waiting for it
  `PSS_NEVER(a_div_done_waiting, clk_i, rst_ni, div_rsp.done && !seek_wait)
  // step position always inside the active pattern
  `PSS_NEVER(a_step_in_len, clk_i, rst_ni, step_q >= len)
  // a finished item reaches the output register when it is free
  `PSS_ASSERT(a_out_loaded, clk_i, rst_ni, (state_q == ST_OUT && !out_valid_q) |=> out_valid_q)
  // a fired step is reported only by a tick
  `PSS_NEVER(a_fire_on_tick, clk_i, rst_ni, fired_q && state_q == ST_OUT && item_q.func != FUNC_TICK)

endmodule

FILE: hdl/pss_div.sv
// Restoring radix-2 divider, 32-bit dividend by 8-bit divisor.
// Depends on pss_pkg (div_req_t, div_rsp_t).
`timescale 1ns / 1ps

module pss_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pss_pkg::div_req_t req_i,
  output pss_pkg::div_rsp_t rsp_o
);
  import pss_pkg::*;

  localparam int CntW = $clog2(DivW);
  localparam logic [CntW-1:0] LastCnt = CntW'(DivW - 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] quo_q;
  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvsW:0]   trial;
  logic [DvsW:0]   diff;
  logic            take;

  // partial remainder with next dividend bit shifted in
  assign trial = {rem_q, quo_q[DivW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], take};
      rem_q <= take ? diff[DvsW-1:0] : trial[DvsW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: hdl/pss_step_mem.sv
// Step table: one write port, one registered read port, per-entry valid bits.
// Depends on pss_pkg (step_entry_t, STEP_RST).
`timescale 1ns / 1ps

module pss_step_mem #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  pss_pkg::step_entry_t wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output pss_pkg::step_entry_t rd_data_o
);
  import pss_pkg::*;

  step_entry_t            mem_q [Depth];
  logic [Depth-1:0]       valid_q;
  step_entry_t            raw_q;
  logic                   hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      raw_q <= mem_q[rd_addr_i];
    end
  end

  // unwritten entries read as the reset pattern
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = hit_q ? raw_q : STEP_RST;

endmodule

FILE: dv/probabilistic_step_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the probabilistic step sequencer.
// Depends on pss_pkg, pss_if and the sequencer RTL; it drives item, register
// and result channels and checks every result transaction against its own model.

module probabilistic_step_sequencer_tb;
  import pss_pkg::*;

  localparam int          TABLE_DEPTH = 64;
  localparam logic [1:0]  FUNC_SPARE  = 2'd3;   // unused item code: no state change
  localparam int unsigned STALL_LIMIT = 3000;   // cycles without any transaction
  localparam int unsigned TAIL_CYCLES = 100;    // covers the slowest item, a seek
  localparam int unsigned LONG_HOLD   = 250;    // receiver back-pressure stretch
  localparam int unsigned HOLD_AT     = 600;    // results taken before that stretch
  localparam int unsigned PAUSE_AT    = 900;    // items sent before the sender drains
  localparam int unsigned MAX_SHOWN   = 200;    // cap on printed mismatches
  localparam int          PHASES      = 10;

  // Playback model plus the queue of expected result transactions.
  class playback_checker;
    logic [7:0]       ticks_reg;
    logic [6:0]       steps_reg;
    logic [NoteW-1:0] note_tbl [TABLE_DEPTH];
    logic [NoteW-1:0] vel_tbl  [TABLE_DEPTH];
    logic [NoteW-1:0] gate_tbl [TABLE_DEPTH];
    logic [NoteW-1:0] prob_tbl [TABLE_DEPTH];
    int unsigned      sub_pos, step_pos, off_pt;
    bit               armed;
    logic [NoteW-1:0] snd_note, snd_vel;
    pss_out_t         expected_q [$];
    int unsigned      errors, shown, items, ticks, fired, seeks, writes;

    function new();
      ticks_reg = TICKS_RST;
      steps_reg = STEPS_RST;
      foreach (note_tbl[i]) begin
        note_tbl[i] = NOTE_RST;
        vel_tbl[i]  = VEL_RST;
        gate_tbl[i] = GATE_RST;
        prob_tbl[i] = PROB_ALWAYS;
      end
      sub_pos = 0; step_pos = 0; off_pt = 0; armed = 0;
      snd_note = '0; snd_vel = '0;
      errors = 0; shown = 0; items = 0; ticks = 0; fired = 0; seeks = 0; writes = 0;
    endfunction

    function int unsigned res_eff();
      return (ticks_reg == 0) ? 1 : 32'(ticks_reg);
    endfunction

    function int unsigned len_eff();
      if (steps_reg == 0) return 1;
      if (steps_reg > TABLE_DEPTH) return TABLE_DEPTH;
      return 32'(steps_reg);
    endfunction

    function void seek_pos(logic [31:0] ph);
      int unsigned r;
      r = res_eff();
      sub_pos  = ph % r;
      step_pos = (ph / r) % len_eff();
    endfunction

    function void write_reg(cfg_reg_e idx, logic [7:0] val);
      if (idx == CFG_TICKS) begin
        ticks_reg = val;
      end else begin
        steps_reg = val[6:0];
        if (step_pos >= len_eff()) seek_pos('0);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Advance the model by one accepted item and queue its result.
    function void note_item(pss_in_t it);
      pss_out_t    want;
      bit          hit;
      int unsigned idx, r;
      hit = 0;
      items++;
      case (it.func)
        FUNC_TICK: begin
          ticks++;
          idx = step_pos % TABLE_DEPTH;
          r   = res_eff();
          if (sub_pos == 0) begin
            armed  = (prob_tbl[idx] == PROB_ALWAYS) || (it.random_value < prob_tbl[idx]);
            off_pt = 1 + (32'(gate_tbl[idx]) * (r - 1)) / 32'(GATE_FULL);
            if (armed) begin
              snd_note = note_tbl[idx];
              snd_vel  = vel_tbl[idx];
              hit = 1;
              fired++;
            end
          end
          // a skipped step leaves earlier sound alone
          if (sub_pos == off_pt && armed) begin
            snd_note = '0;
            snd_vel  = '0;
          end
          sub_pos++;
          if (sub_pos >= r) begin
            sub_pos = 0;
            step_pos++;
            if (step_pos >= len_eff()) step_pos = 0;
          end
        end
        FUNC_SEEK: begin
          seeks++;
          seek_pos(it.playhead);
        end
        FUNC_WRITE: begin
          writes++;
          if (it.step_index < TABLE_DEPTH) begin
            note_tbl[it.step_index] = it.note_in;
            vel_tbl[it.step_index]  = it.velocity_in;
            gate_tbl[it.step_index] = it.gate_in;
            prob_tbl[it.step_index] = it.probability_in;
          end
        end
        default: ;
      endcase
      want.note_out     = snd_note;
      want.velocity_out = snd_vel;
      want.step_now     = step_pos[5:0];
      want.substep_now  = sub_pos[7:0];
      want.step_fired   = hit;
      expected_q.push_back(want);
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      if (shown < MAX_SHOWN) begin
        shown++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_playback(pss_out_t got);
      pss_out_t want;
      if (expected_q.size() == 0) begin
        flag("unexpected result, pending count", 0, 1);
        return;
      end
      want = expected_q.pop_front();
      if (want.note_out !== got.note_out)
        flag("note_out", 32'(want.note_out), 32'(got.note_out));
      if (want.velocity_out !== got.velocity_out)
        flag("velocity_out", 32'(want.velocity_out), 32'(got.velocity_out));
      if (want.step_now !== got.step_now)
        flag("step_now", 32'(want.step_now), 32'(got.step_now));
      if (want.substep_now !== got.substep_now)
        flag("substep_now", 32'(want.substep_now), 32'(got.substep_now));
      if (want.step_fired !== got.step_fired)
        flag("step_fired", 32'(want.step_fired), 32'(got.step_fired));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_reg_e            cfg_idx_i;
  logic [CfgW-1:0]     cfg_wdata_i;

  pss_in_if  in_ch ();
  pss_out_if out_ch ();

  playback_checker book = new();

  probabilistic_step_sequencer #(
    .MAX_STEPS(TABLE_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Item with every field random, func fixed; unused fields carry noise.
  function automatic pss_in_t make_item(logic [1:0] f);
    pss_in_t it;
    it.func           = f;
    it.playhead       = $urandom();
    it.step_index     = 6'($urandom_range(TABLE_DEPTH - 1, 0));
    it.note_in        = 7'($urandom_range(127, 0));
    it.velocity_in    = 7'($urandom_range(127, 0));
    it.gate_in        = 7'($urandom_range(127, 0));
    it.probability_in = 7'($urandom_range(127, 0));
    it.random_value   = 7'($urandom_range(127, 0));
    return it;
  endfunction

  function automatic pss_in_t entry_item(int idx, int n, int v, int g, int p);
    pss_in_t it;
    it = make_item(FUNC_WRITE);
    it.step_index     = 6'(idx);
    it.note_in        = 7'(n);
    it.velocity_in    = 7'(v);
    it.gate_in        = 7'(g);
    it.probability_in = 7'(p);
    return it;
  endfunction

  function automatic pss_in_t tick_item(int rnd);
    pss_in_t it;
    it = make_item(FUNC_TICK);
    it.random_value = 7'(rnd);
    return it;
  endfunction

  function automatic pss_in_t seek_item(logic [31:0] ph);
    pss_in_t it;
    it = make_item(FUNC_SEEK);
    it.playhead = ph;
    return it;
  endfunction

  // Mostly ticks; seeks often land on step boundaries so that steps get
  // a chance to fire even at long resolutions.
  function automatic pss_in_t random_item();
    pss_in_t     it;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 60) begin
      it = make_item(FUNC_TICK);
    end else if (pick < 70) begin
      it = make_item(FUNC_SEEK);
      case ($urandom_range(2, 0))
        0: ;
        1: it.playhead = $urandom_range(4000, 0);
        default: it.playhead = book.res_eff() * $urandom_range(300, 0);
      endcase
    end else if (pick < 95) begin
      it = make_item(FUNC_WRITE);
      if ($urandom_range(1, 0) == 1) it.probability_in = PROB_ALWAYS;
    end else begin
      it = make_item(FUNC_SPARE);
    end
    return it;
  endfunction

  // Offer one item after an optional gap; returns at the accepting edge.
  // Valid is never lowered and raised in the same step.
  task automatic offer_item(input pss_in_t it, input int unsigned gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    book.note_item(it);
  endtask

  // Drain the block, then write both registers while it is idle.
  task automatic retune(input logic [7:0] ticks_val, input logic [7:0] steps_val);
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (book.pending() != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_TICKS;
    cfg_wdata_i <= ticks_val;
    @(posedge clk_i);
    book.write_reg(CFG_TICKS, ticks_val);
    cfg_idx_i   <= CFG_STEPS;
    cfg_wdata_i <= steps_val;
    @(posedge clk_i);
    book.write_reg(CFG_STEPS, steps_val);
    cfg_we_i <= 1'b0;
  endtask

  // Main stimulus: reset, directed items, then random phases over a range
  // of register settings, extremes first.
  initial begin : stimulus
    int unsigned plan_ticks [PHASES];
    int unsigned plan_steps [PHASES];
    int unsigned plan_items [PHASES];
    int unsigned sent, burst_left, gap;
    pss_in_t     it;

    plan_ticks = '{0, 1,   255, 2,  6,   24,  128, 4,   0,  0};
    plan_steps = '{0, 127, 64,  65, 5,   16,  33,  8,   0,  0};
    plan_items = '{150, 200, 160, 220, 200, 180, 150, 200, 80, 80};
    sent = 0;
    burst_left = 0;

    rst_ni      <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_TICKS;
    cfg_wdata_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // At reset settings (24 ticks, 16 steps): step 0 holds the reset entry,
    // which always fires; then a seek to the top of the playhead range.
    offer_item(tick_item(0), 0);
    offer_item(seek_item(32'hFFFF_FFFF), $urandom_range(2, 0));

    // Short pattern; shrinking the length also sends the position home.
    retune(8'd3, 8'd4);
    offer_item(entry_item(0, 127, 127, 127, 127), 0);   // loudest, held through
    offer_item(entry_item(1, 1, 2, 0, 0), $urandom_range(2, 0));  // never fires
    offer_item(entry_item(2, 5, 6, 64, 126), 0);        // fires only below 126
    offer_item(entry_item(TABLE_DEPTH - 1, 0, 0, 0, 0), 0);  // last entry, unused
    offer_item(tick_item(127), 0);                      // step 0 fires
    repeat (2) offer_item(tick_item($urandom_range(127, 0)), $urandom_range(2, 0));
    offer_item(tick_item(0), 0);       // step 1 skipped, step 0 sound kept
    repeat (2) offer_item(tick_item($urandom_range(127, 0)), 0);
    offer_item(tick_item(126), 0);     // draw equal to probability: no fire
    repeat (2) offer_item(tick_item($urandom_range(127, 0)), $urandom_range(2, 0));
    offer_item(tick_item(0), 0);       // untouched entry, silent velocity
    repeat (2) offer_item(tick_item($urandom_range(127, 0)), 0);  // wraps to step 0
    offer_item(make_item(FUNC_SPARE), 0);
    offer_item(seek_item(32'hFFFF_FFFF), 0);
    offer_item(seek_item(32'd0), $urandom_range(2, 0));
    offer_item(seek_item(32'd6), 0);   // step 2, substep 0
    offer_item(tick_item(125), 0);     // fires just under probability
    repeat (2) offer_item(tick_item($urandom_range(127, 0)), 0);  // off point

    // Random phases. The sender runs bursts with gaps; some bursts carry
    // no gap at all.
    for (int p = 0; p < PHASES; p++) begin
      if (p >= PHASES - 2) begin
        plan_ticks[p] = $urandom_range(12, 1);
        plan_steps[p] = $urandom_range(TABLE_DEPTH, 1);
      end
      retune(8'(plan_ticks[p]), 8'(plan_steps[p]));
      for (int n = 0; n < plan_items[p]; n++) begin
        if (sent == PAUSE_AT) begin
          // let the block run dry before carrying on
          in_ch.valid <= 1'b0;
          do @(posedge clk_i); while (book.pending() != 0);
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(24, 1);
          gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
        end else begin
          gap = 0;
        end
        burst_left--;
        it = random_item();
        offer_item(it, gap);
        sent++;
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (book.pending() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d items: %0d ticks (%0d fired steps), %0d seeks, %0d table writes,",
             book.items, book.ticks, book.fired, book.seeks, book.writes);
    $display("over %0d register settings with random gaps and receiver back-pressure.",
             PHASES + 2);
    if (book.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: checks each transaction and stalls on a randomly redrawn pattern,
  // plus one long hold-off so the block backs up.
  initial begin : receiver
    int unsigned cyc, hold_left, mode, taken;
    bit          held;
    cyc = 0; hold_left = 0; mode = 0; taken = 0; held = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        book.check_playback(out_ch.data);
        taken++;
        if (taken == HOLD_AT && !held) begin
          hold_left = LONG_HOLD;
          held = 1;
        end
      end
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(3, 0);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(3, 0) != 0);
          2: out_ch.ready <= ($urandom_range(3, 0) == 0);
          default: out_ch.ready <= ((cyc / 4) % 2 == 0);
        endcase
      end
    end
  end

  // Ends the run if neither channel moves a transaction for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, book.pending());
    $display("Some tests failed");
    $finish;
  end

endmodule
